FILE: rtl/core/plp_pkg.sv
// ----------------------------------------------------------------------------
// plp_pkg
// types, widths and latency constants shared by the point-line projection core
// ----------------------------------------------------------------------------
package plp_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int QUOT_W      = COORD_WIDTH + 1;
    localparam int SQRT_STEPS  = SUM_W / 2;
    localparam int DIST_LAT    = 3 + SQRT_STEPS + 1;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]      t_diff;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vec;

    typedef struct packed {
        t_diff x;
        t_diff y;
        t_diff z;
    } t_dvec;

    typedef struct packed {
        t_vec p;
        t_vec a;
        t_vec b;
    } t_geom;

    typedef struct packed {
        t_geom geom;
        t_dvec v;
        logic  degen;
    } t_ctx;

    typedef struct packed {
        t_coord lam;
        t_vec   foot;
        logic   degen;
    } t_hold;

    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        t_coord point_z;
        t_coord start_x;
        t_coord start_y;
        t_coord start_z;
        t_coord end_x;
        t_coord end_y;
        t_coord end_z;
    } t_in_word;

    typedef struct packed {
        t_coord                 line_param;
        t_coord                 foot_x;
        t_coord                 foot_y;
        t_coord                 foot_z;
        logic [COORD_WIDTH-1:0] dist_to_point;
        logic [COORD_WIDTH-1:0] dist_to_start;
        logic [COORD_WIDTH-1:0] dist_to_end;
        logic                   degenerate;
    } t_out_word;

endpackage

FILE: rtl/core/plp_dot.sv
// ----------------------------------------------------------------------------
// plp_dot
// direction vectors, dot product and squared line length, three stages
// ----------------------------------------------------------------------------
module plp_dot (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  plp_pkg::t_in_word                 i_word,
    output logic                              o_valid,
    output plp_pkg::t_ctx                     o_ctx,
    output logic signed [plp_pkg::SUM_W-1:0]  o_dot,
    output logic [plp_pkg::SUM_W-1:0]         o_vv
);
    localparam int DW = plp_pkg::DIFF_W;
    localparam int PW = plp_pkg::PROD_W;
    localparam int SW = plp_pkg::SUM_W;

    plp_pkg::t_coord     w_p [3];
    plp_pkg::t_coord     w_a [3];
    plp_pkg::t_coord     w_b [3];
    logic signed [DW-1:0] w_u [3];
    logic signed [DW-1:0] w_v [3];

    logic                 r_valid1;
    plp_pkg::t_geom       r_geom1;
    logic signed [DW-1:0] r_u1 [3];
    logic signed [DW-1:0] r_v1 [3];

    logic                 r_valid2;
    plp_pkg::t_geom       r_geom2;
    logic signed [DW-1:0] r_v2 [3];
    logic signed [PW-1:0] r_uv2 [3];
    logic signed [PW-1:0] r_vv2 [3];

    logic                 r_valid3;
    plp_pkg::t_geom       r_geom3;
    logic signed [DW-1:0] r_v3 [3];
    logic signed [SW-1:0] r_dot3;
    logic [SW-1:0]        r_vv3;

    assign w_p[0] = i_word.point_x;
    assign w_p[1] = i_word.point_y;
    assign w_p[2] = i_word.point_z;
    assign w_a[0] = i_word.start_x;
    assign w_a[1] = i_word.start_y;
    assign w_a[2] = i_word.start_z;
    assign w_b[0] = i_word.end_x;
    assign w_b[1] = i_word.end_y;
    assign w_b[2] = i_word.end_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_u[k] = DW'(w_p[k]) - DW'(w_a[k]);
            w_v[k] = DW'(w_b[k]) - DW'(w_a[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
        end else begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
            r_valid3 <= r_valid2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_geom1.p <= '{x: w_p[0], y: w_p[1], z: w_p[2]};
        r_geom1.a <= '{x: w_a[0], y: w_a[1], z: w_a[2]};
        r_geom1.b <= '{x: w_b[0], y: w_b[1], z: w_b[2]};
        for (int k = 0; k < 3; k++) begin
            r_u1[k]  <= w_u[k];
            r_v1[k]  <= w_v[k];
            r_v2[k]  <= r_v1[k];
            r_uv2[k] <= r_u1[k] * r_v1[k];
            r_vv2[k] <= r_v1[k] * r_v1[k];
            r_v3[k]  <= r_v2[k];
        end
        r_geom2 <= r_geom1;
        r_geom3 <= r_geom2;
        r_dot3  <= SW'(r_uv2[0]) + SW'(r_uv2[1]) + SW'(r_uv2[2]);
        r_vv3   <= $unsigned(SW'(r_vv2[0]) + SW'(r_vv2[1]) + SW'(r_vv2[2]));
    end

    assign o_valid      = r_valid3;
    assign o_dot        = r_dot3;
    assign o_vv         = r_vv3;
    assign o_ctx.geom   = r_geom3;
    assign o_ctx.v      = '{x: r_v3[0], y: r_v3[1], z: r_v3[2]};
    assign o_ctx.degen  = (r_vv3 == '0);

endmodule

FILE: rtl/core/plp_div.sv
// ----------------------------------------------------------------------------
// plp_div
// pipelined restoring divider for the line parameter, one quotient bit a stage
// ----------------------------------------------------------------------------
module plp_div #(
    parameter int FRAC_BITS = plp_pkg::FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  plp_pkg::t_ctx                       i_ctx,
    input  logic signed [plp_pkg::SUM_W-1:0]    i_dot,
    input  logic [plp_pkg::SUM_W-1:0]           i_vv,
    output logic                                o_valid,
    output plp_pkg::t_ctx                       o_ctx,
    output plp_pkg::t_coord                     o_lam
);
    localparam int W  = plp_pkg::COORD_WIDTH;
    localparam int SW = plp_pkg::SUM_W;
    localparam int QB = plp_pkg::QUOT_W;
    localparam int RW = SW + QB;
    localparam logic [QB:0] QMAX = {2'b00, {(W-1){1'b1}}};
    localparam logic [QB:0] QMIN = QMAX + 1'b1;

    logic [SW-1:0] w_mag;
    logic [RW-1:0] w_num;

    logic          r_a_valid;
    logic [RW-1:0] r_a_num;
    logic [SW-1:0] r_a_vv;
    logic          r_a_neg;
    plp_pkg::t_ctx r_a_ctx;

    logic          r_dvalid [QB+1];
    logic [RW-1:0] r_rem    [QB+1];
    logic [QB-1:0] r_q      [QB+1];
    logic [SW-1:0] r_dvv    [QB+1];
    logic          r_dneg   [QB+1];
    logic          r_dovf   [QB+1];
    plp_pkg::t_ctx r_dctx   [QB+1];

    logic          r_r_valid;
    logic [QB:0]   r_r_q;
    logic          r_r_neg;
    logic          r_r_ovf;
    plp_pkg::t_ctx r_r_ctx;

    logic          r_o_valid;
    plp_pkg::t_coord r_o_lam;
    plp_pkg::t_ctx r_o_ctx;

    logic [SW:0]   w_rem2;
    logic          w_round;
    logic [QB:0]   w_negq;
    plp_pkg::t_coord w_lam;

    assign w_mag = i_dot[SW-1] ? $unsigned(-i_dot) : $unsigned(i_dot);
    assign w_num = RW'(w_mag) << FRAC_BITS;

    // magnitude and scaling
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_num <= w_num;
        r_a_vv  <= i_vv;
        r_a_neg <= i_dot[SW-1];
        r_a_ctx <= i_ctx;
    end

    // quotient overflow check
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvalid[0] <= 1'b0;
        end else begin
            r_dvalid[0] <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= r_a_num;
        r_q[0]    <= '0;
        r_dvv[0]  <= r_a_vv;
        r_dneg[0] <= r_a_neg;
        r_dovf[0] <= (r_a_num >= (RW'(r_a_vv) << QB));
        r_dctx[0] <= r_a_ctx;
    end

    for (genvar k = 0; k < QB; k++) begin : g_step
        logic [RW-1:0] w_sub;
        logic          w_bit;

        assign w_sub = RW'(r_dvv[k]) << (QB - 1 - k);
        assign w_bit = (r_rem[k] >= w_sub);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvalid[k+1] <= 1'b0;
            end else begin
                r_dvalid[k+1] <= r_dvalid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= w_bit ? (r_rem[k] - w_sub) : r_rem[k];
            r_q[k+1]    <= {r_q[k][QB-2:0], w_bit};
            r_dvv[k+1]  <= r_dvv[k];
            r_dneg[k+1] <= r_dneg[k];
            r_dovf[k+1] <= r_dovf[k];
            r_dctx[k+1] <= r_dctx[k];
        end
    end

    // round to nearest, ties away from zero
    assign w_rem2  = {r_rem[QB][SW-1:0], 1'b0};
    assign w_round = (w_rem2 >= {1'b0, r_dvv[QB]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_r_valid <= r_dvalid[QB];
            r_o_valid <= r_r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r_q   <= (QB+1)'(r_q[QB]) + (QB+1)'(w_round);
        r_r_neg <= r_dneg[QB];
        r_r_ovf <= r_dovf[QB];
        r_r_ctx <= r_dctx[QB];
    end

    // saturate and apply sign
    assign w_negq = '0 - r_r_q;

    always_comb begin
        if (r_r_ctx.degen) begin
            w_lam = '0;
        end else if (!r_r_neg) begin
            w_lam = (r_r_ovf || (r_r_q > QMAX)) ? QMAX[W-1:0] : r_r_q[W-1:0];
        end else begin
            w_lam = (r_r_ovf || (r_r_q > QMIN)) ? QMIN[W-1:0] : w_negq[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_lam <= w_lam;
        r_o_ctx <= r_r_ctx;
    end

    assign o_valid = r_o_valid;
    assign o_lam   = r_o_lam;
    assign o_ctx   = r_o_ctx;

endmodule

FILE: rtl/core/plp_foot.sv
// ----------------------------------------------------------------------------
// plp_foot
// foot of the perpendicular: scaled direction added to the start point
// ----------------------------------------------------------------------------
module plp_foot #(
    parameter int FRAC_BITS = plp_pkg::FRAC_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  plp_pkg::t_ctx   i_ctx,
    input  plp_pkg::t_coord i_lam,
    output logic            o_valid,
    output plp_pkg::t_ctx   o_ctx,
    output plp_pkg::t_coord o_lam,
    output plp_pkg::t_vec   o_foot
);
    localparam int W  = plp_pkg::COORD_WIDTH;
    localparam int DW = plp_pkg::DIFF_W;
    localparam int MW = 2 * DW;
    localparam int TW = MW + 1;
    localparam int FW = TW + 2;
    localparam logic [TW-1:0]        HALF = ({{(TW-1){1'b0}}, 1'b1} << FRAC_BITS) >> 1;
    localparam logic signed [FW-1:0] SMAX = FW'({1'b0, {(W-1){1'b1}}});
    localparam logic signed [FW-1:0] SMIN = -SMAX - 1;

    logic signed [DW-1:0] w_v   [3];
    logic [DW-1:0]        w_vm  [3];
    logic [DW-1:0]        w_lm;
    logic signed [DW-1:0] w_lx;

    logic            r_m_valid;
    logic [MW-1:0]   r_m_prod [3];
    logic            r_m_sgn  [3];
    plp_pkg::t_coord r_m_lam;
    plp_pkg::t_ctx   r_m_ctx;

    plp_pkg::t_coord w_a [3];
    logic [TW-1:0]        w_t   [3];
    logic signed [FW-1:0] w_ts  [3];
    logic signed [FW-1:0] w_sum [3];
    plp_pkg::t_coord      w_ft  [3];

    logic            r_s_valid;
    plp_pkg::t_coord r_s_foot [3];
    plp_pkg::t_coord r_s_lam;
    plp_pkg::t_ctx   r_s_ctx;

    assign w_v[0] = i_ctx.v.x;
    assign w_v[1] = i_ctx.v.y;
    assign w_v[2] = i_ctx.v.z;
    assign w_lx   = DW'(i_lam);
    assign w_lm   = w_lx[DW-1] ? $unsigned(-w_lx) : $unsigned(w_lx);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_vm[k] = w_v[k][DW-1] ? $unsigned(-w_v[k]) : $unsigned(w_v[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else begin
            r_m_valid <= i_valid;
            r_s_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_m_prod[k] <= MW'(w_lm) * MW'(w_vm[k]);
            r_m_sgn[k]  <= w_lx[DW-1] ^ w_v[k][DW-1];
        end
        r_m_lam <= i_lam;
        r_m_ctx <= i_ctx;
    end

    assign w_a[0] = r_m_ctx.geom.a.x;
    assign w_a[1] = r_m_ctx.geom.a.y;
    assign w_a[2] = r_m_ctx.geom.a.z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_t[k]   = (TW'(r_m_prod[k]) + HALF) >> FRAC_BITS;
            w_ts[k]  = r_m_sgn[k] ? -$signed(FW'(w_t[k])) : $signed(FW'(w_t[k]));
            w_sum[k] = FW'(w_a[k]) + w_ts[k];
            if (w_sum[k] > SMAX) begin
                w_ft[k] = SMAX[W-1:0];
            end else if (w_sum[k] < SMIN) begin
                w_ft[k] = SMIN[W-1:0];
            end else begin
                w_ft[k] = w_sum[k][W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_s_foot[k] <= w_ft[k];
        end
        r_s_lam <= r_m_lam;
        r_s_ctx <= r_m_ctx;
    end

    assign o_valid = r_s_valid;
    assign o_ctx   = r_s_ctx;
    assign o_lam   = r_s_lam;
    assign o_foot  = '{x: r_s_foot[0], y: r_s_foot[1], z: r_s_foot[2]};

endmodule

FILE: rtl/core/plp_dist.sv
// ----------------------------------------------------------------------------
// plp_dist
// euclidean distance: squared differences, pipelined square root, rounding
// ----------------------------------------------------------------------------
module plp_dist (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  plp_pkg::t_vec                    i_x,
    input  plp_pkg::t_vec                    i_y,
    output logic                             o_valid,
    output logic [plp_pkg::COORD_WIDTH-1:0]  o_dist
);
    localparam int W  = plp_pkg::COORD_WIDTH;
    localparam int DW = plp_pkg::DIFF_W;
    localparam int PW = plp_pkg::PROD_W;
    localparam int SW = plp_pkg::SUM_W;
    localparam int NS = plp_pkg::SQRT_STEPS;
    localparam int QW = SW + 1;

    plp_pkg::t_coord w_x [3];
    plp_pkg::t_coord w_y [3];

    logic                 r_d_valid;
    logic signed [DW-1:0] r_d [3];
    logic                 r_q_valid;
    logic signed [PW-1:0] r_sq [3];

    logic          r_vld [NS+1];
    logic [QW-1:0] r_num [NS+1];
    logic [QW-1:0] r_res [NS+1];

    logic          r_o_valid;
    logic [W-1:0]  r_o_dist;
    logic [W+1:0]  w_root;

    assign w_x[0] = i_x.x;
    assign w_x[1] = i_x.y;
    assign w_x[2] = i_x.z;
    assign w_y[0] = i_y.x;
    assign w_y[1] = i_y.y;
    assign w_y[2] = i_y.z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_q_valid <= 1'b0;
            r_vld[0]  <= 1'b0;
        end else begin
            r_d_valid <= i_valid;
            r_q_valid <= r_d_valid;
            r_vld[0]  <= r_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_d[k]  <= DW'(w_x[k]) - DW'(w_y[k]);
            r_sq[k] <= r_d[k] * r_d[k];
        end
        r_num[0] <= $unsigned(QW'(r_sq[0]) + QW'(r_sq[1]) + QW'(r_sq[2]));
        r_res[0] <= '0;
    end

    for (genvar k = 0; k < NS; k++) begin : g_root
        logic [QW-1:0] w_bitv;
        logic [QW-1:0] w_t;
        logic          w_take;

        assign w_bitv = {{(QW-1){1'b0}}, 1'b1} << (2 * (NS - 1 - k));
        assign w_t    = r_res[k] + w_bitv;
        assign w_take = (r_num[k] >= w_t);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_num[k+1] <= w_take ? (r_num[k] - w_t) : r_num[k];
            r_res[k+1] <= w_take ? ((r_res[k] >> 1) + w_bitv) : (r_res[k] >> 1);
        end
    end

    // round to nearest and saturate
    assign w_root = r_res[NS][W+1:0] + (W+2)'(r_num[NS] > r_res[NS]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= r_vld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_dist <= (w_root[W+1:W] != 2'b00) ? {W{1'b1}} : w_root[W-1:0];
    end

    assign o_valid = r_o_valid;
    assign o_dist  = r_o_dist;

endmodule

FILE: rtl/core/point_line_projection_core.sv
// ----------------------------------------------------------------------------
// point_line_projection_core
// orthogonal projection of a point onto a 3d line, signed fixed point
// ----------------------------------------------------------------------------
// usage:
//   a query word (point, line start, line end) is taken at every rising edge
//   with i_start high and o_busy low; o_busy stays low, so a new word may
//   enter in every cycle and one word per cycle is sustained
//   the result word (line parameter, foot point, three distances, degenerate
//   flag) appears on o_word for one cycle with o_done high
//   the divider produces one quotient bit per stage and the square root
//   one root bit per stage
//   results leave in the order the queries came in
//   reset empties the pipeline: no o_done follows a reset until new words
//   are taken; the receiver cannot hold results off and none is needed
// ----------------------------------------------------------------------------
module point_line_projection_core #(
    parameter int FRAC_BITS = plp_pkg::FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  plp_pkg::t_in_word  i_word,
    output logic               o_done,
    output plp_pkg::t_out_word o_word
);
    localparam int NH = plp_pkg::DIST_LAT;

    logic                             w_take;
    logic                             w_dot_valid;
    plp_pkg::t_ctx                    w_dot_ctx;
    logic signed [plp_pkg::SUM_W-1:0] w_dot;
    logic [plp_pkg::SUM_W-1:0]        w_vv;

    logic            w_div_valid;
    plp_pkg::t_ctx   w_div_ctx;
    plp_pkg::t_coord w_div_lam;

    logic            w_ft_valid;
    plp_pkg::t_ctx   w_ft_ctx;
    plp_pkg::t_coord w_ft_lam;
    plp_pkg::t_vec   w_foot;

    logic [2:0]                       w_dvalid;
    logic [plp_pkg::COORD_WIDTH-1:0]  w_dist [3];

    plp_pkg::t_hold r_hold [NH];

    assign o_busy = 1'b0;
    assign w_take = i_start && !o_busy;

    plp_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_take),
        .i_word  (i_word),
        .o_valid (w_dot_valid),
        .o_ctx   (w_dot_ctx),
        .o_dot   (w_dot),
        .o_vv    (w_vv)
    );

    plp_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dot_valid),
        .i_ctx   (w_dot_ctx),
        .i_dot   (w_dot),
        .i_vv    (w_vv),
        .o_valid (w_div_valid),
        .o_ctx   (w_div_ctx),
        .o_lam   (w_div_lam)
    );

    plp_foot #(
        .FRAC_BITS (FRAC_BITS)
    ) u_foot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_div_valid),
        .i_ctx   (w_div_ctx),
        .i_lam   (w_div_lam),
        .o_valid (w_ft_valid),
        .o_ctx   (w_ft_ctx),
        .o_lam   (w_ft_lam),
        .o_foot  (w_foot)
    );

    plp_dist u_dist_point (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_ft_valid),
        .i_x     (w_ft_ctx.geom.p),
        .i_y     (w_foot),
        .o_valid (w_dvalid[0]),
        .o_dist  (w_dist[0])
    );

    plp_dist u_dist_start (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_ft_valid),
        .i_x     (w_foot),
        .i_y     (w_ft_ctx.geom.a),
        .o_valid (w_dvalid[1]),
        .o_dist  (w_dist[1])
    );

    plp_dist u_dist_end (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_ft_valid),
        .i_x     (w_foot),
        .i_y     (w_ft_ctx.geom.b),
        .o_valid (w_dvalid[2]),
        .o_dist  (w_dist[2])
    );

    // line parameter and foot wait beside the distance pipelines
    always_ff @(posedge i_clk) begin
        r_hold[0] <= '{lam: w_ft_lam, foot: w_foot, degen: w_ft_ctx.degen};
        for (int k = 1; k < NH; k++) begin
            r_hold[k] <= r_hold[k-1];
        end
    end

    assign o_done                = w_dvalid[0] && w_dvalid[1] && w_dvalid[2];
    assign o_word.line_param     = r_hold[NH-1].lam;
    assign o_word.foot_x         = r_hold[NH-1].foot.x;
    assign o_word.foot_y         = r_hold[NH-1].foot.y;
    assign o_word.foot_z         = r_hold[NH-1].foot.z;
    assign o_word.dist_to_point  = w_dist[0];
    assign o_word.dist_to_start  = w_dist[1];
    assign o_word.dist_to_end    = w_dist[2];
    assign o_word.degenerate     = r_hold[NH-1].degen;

endmodule

FILE: dv/plp_checker.sv
// ----------------------------------------------------------------------------
// plp_checker
// predicts every projection result from the accepted query words and
// compares each o_done word as a whole with the oldest prediction
// ----------------------------------------------------------------------------
module plp_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  plp_pkg::t_in_word  i_word,
    input  logic               i_done,
    input  plp_pkg::t_out_word i_result,
    output int                 o_fail_count,
    output int                 o_pending
);
    localparam int FB = plp_pkg::FRAC_BITS;
    localparam int CW = plp_pkg::COORD_WIDTH;

    plp_pkg::t_out_word expected_results[$];
    int                 mismatches;

    function automatic logic signed [63:0] sat_coord(logic signed [127:0] x);
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = (128'sd1 <<< (CW - 1)) - 1;
        lo = -(128'sd1 <<< (CW - 1));
        if (x > hi) begin
            return hi[63:0];
        end else if (x < lo) begin
            return lo[63:0];
        end
        return x[63:0];
    endfunction

    function automatic logic [CW-1:0] round_sqrt(logic [127:0] n);
        logic [127:0] res;
        logic [127:0] bitv;
        logic [127:0] t;
        res  = '0;
        bitv = 128'h1 << 126;
        while (bitv != 0 && bitv > n) begin
            bitv = bitv >> 2;
        end
        while (bitv != 0) begin
            t = res + bitv;
            if (n >= t) begin
                n   = n - t;
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        if (n > res) begin
            res = res + 1;
        end
        if (res > {CW{1'b1}}) begin
            return {CW{1'b1}};
        end
        return res[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] euclid_dist(logic signed [63:0] x[3],
                                                  logic signed [63:0] y[3]);
        logic signed [127:0] d;
        logic        [127:0] s;
        s = '0;
        for (int k = 0; k < 3; k++) begin
            d = 128'(x[k]) - 128'(y[k]);
            s = s + 128'(d * d);
        end
        return round_sqrt(s);
    endfunction

    function automatic plp_pkg::t_out_word project_point(plp_pkg::t_in_word w);
        plp_pkg::t_out_word  r;
        logic signed [63:0]  p[3];
        logic signed [63:0]  a[3];
        logic signed [63:0]  b[3];
        logic signed [63:0]  v[3];
        logic signed [63:0]  foot[3];
        logic signed [127:0] dot;
        logic signed [127:0] vv;
        logic signed [127:0] t;
        logic        [127:0] num;
        logic        [127:0] q;
        logic        [127:0] rem;
        logic signed [63:0]  lam;
        logic        [63:0]  lam_mag;
        logic        [63:0]  v_mag;
        p = '{64'(w.point_x), 64'(w.point_y), 64'(w.point_z)};
        a = '{64'(w.start_x), 64'(w.start_y), 64'(w.start_z)};
        b = '{64'(w.end_x), 64'(w.end_y), 64'(w.end_z)};
        dot = '0;
        vv  = '0;
        for (int k = 0; k < 3; k++) begin
            v[k] = b[k] - a[k];
            dot  = dot + 128'(p[k] - a[k]) * 128'(v[k]);
            vv   = vv + 128'(v[k]) * 128'(v[k]);
        end
        lam = '0;
        if (vv != 0) begin
            num = (dot < 0) ? 128'(-dot) : 128'(dot);
            num = num << FB;
            q   = num / vv;
            rem = num % vv;
            if ((rem << 1) >= vv) begin
                q = q + 1;
            end
            t   = (dot < 0) ? -$signed(q) : $signed(q);
            lam = sat_coord(t);
        end
        lam_mag = (lam < 0) ? -lam : lam;
        for (int k = 0; k < 3; k++) begin
            v_mag = (v[k] < 0) ? -v[k] : v[k];
            t = $signed(128'(lam_mag) * 128'(v_mag));
            if (FB > 0) begin
                t = t + (128'sd1 <<< (FB - 1));
            end
            t = t >>> FB;
            if ((lam < 0) != (v[k] < 0)) begin
                t = -t;
            end
            foot[k] = sat_coord(128'(a[k]) + t);
        end
        r.line_param    = lam[CW-1:0];
        r.foot_x        = foot[0][CW-1:0];
        r.foot_y        = foot[1][CW-1:0];
        r.foot_z        = foot[2][CW-1:0];
        r.dist_to_point = euclid_dist(p, foot);
        r.dist_to_start = euclid_dist(foot, a);
        r.dist_to_end   = euclid_dist(foot, b);
        r.degenerate    = (vv == 0);
        return r;
    endfunction

    assign o_fail_count = mismatches;
    assign o_pending    = expected_results.size();

    initial begin
        mismatches = 0;
    end

    always @(posedge i_clk) begin
        plp_pkg::t_out_word e;
        if (i_rst_n && i_done) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result word %h", i_result);
                end
            end else begin
                e = expected_results.pop_front();
                if (e !== i_result) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: lam %h/%h foot %h %h %h / %h %h %h",
                                 e.line_param, i_result.line_param, e.foot_x, e.foot_y,
                                 e.foot_z, i_result.foot_x, i_result.foot_y, i_result.foot_z);
                        $display("  dist %h %h %h / %h %h %h degen %b/%b",
                                 e.dist_to_point, e.dist_to_start, e.dist_to_end,
                                 i_result.dist_to_point, i_result.dist_to_start,
                                 i_result.dist_to_end, e.degenerate, i_result.degenerate);
                    end
                end
            end
        end
        if (i_rst_n && i_start && !i_busy) begin
            expected_results.push_back(project_point(i_word));
        end
    end
endmodule

FILE: dv/tb_point_line_projection_core.sv
// ----------------------------------------------------------------------------
// tb_point_line_projection_core
// drives directed and random query words into the projection core with
// random sender gaps (none in the last third of the random words); a
// checker beside the block predicts and compares
module tb_point_line_projection_core;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_WORDS   = 1800;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    plp_pkg::t_in_word  i_word;
    logic               o_done;
    plp_pkg::t_out_word o_word;
    int                 fail_count;
    int                 pending;
    int                 idle_pct;
    int                 quiet_cycles;

    point_line_projection_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .o_busy (o_busy),
        .i_word (i_word),
        .o_done (o_done),
        .o_word (o_word)
    );

    plp_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_busy      (o_busy),
        .i_word      (i_word),
        .i_done      (o_done),
        .i_result    (o_word),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** point_line_projection_core: FAILED **");
            $finish;
        end
    end

    // gaps are decided at the falling edge, then the word is held until taken
    task automatic send_word(plp_pkg::t_in_word w);
        while ($urandom_range(99) < idle_pct) begin
            i_start = 1'b0;
            @(negedge i_clk);
        end
        i_start = 1'b1;
        i_word  = w;
        @(posedge i_clk);
        while (o_busy) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_start = 1'b0;
    endtask

    function automatic plp_pkg::t_coord rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(2097151)) - 1048576;
            2: return $signed($urandom_range(511)) - 256;
            default: begin
                case ($urandom_range(3))
                    0: return 32'h7fffffff;
                    1: return 32'h80000000;
                    2: return '0;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    function automatic plp_pkg::t_in_word rand_query();
        plp_pkg::t_in_word w;
        int mode;
        int shape;
        mode  = $urandom_range(3);
        shape = $urandom_range(9);
        w.point_x = rand_coord(mode);
        w.point_y = rand_coord(mode);
        w.point_z = rand_coord(mode);
        w.start_x = rand_coord(mode);
        w.start_y = rand_coord(mode);
        w.start_z = rand_coord(mode);
        w.end_x   = rand_coord(mode);
        w.end_y   = rand_coord(mode);
        w.end_z   = rand_coord(mode);
        if (shape == 0) begin
            w.end_x = w.start_x;
            w.end_y = w.start_y;
            w.end_z = w.start_z;
        end else if (shape == 1) begin
            w.end_x = w.start_x + rand_coord(2);
            w.end_y = w.start_y + rand_coord(2);
            w.end_z = w.start_z + rand_coord(2);
        end else if (shape == 2) begin
            w.point_x = w.start_x;
            w.point_y = w.start_y;
            w.point_z = w.start_z;
        end
        return w;
    endfunction

    function automatic plp_pkg::t_in_word make_query(
        plp_pkg::t_coord px, plp_pkg::t_coord py, plp_pkg::t_coord pz,
        plp_pkg::t_coord ax, plp_pkg::t_coord ay, plp_pkg::t_coord az,
        plp_pkg::t_coord bx, plp_pkg::t_coord by, plp_pkg::t_coord bz);
        plp_pkg::t_in_word w;
        w = '{px, py, pz, ax, ay, az, bx, by, bz};
        return w;
    endfunction

    initial begin
        plp_pkg::t_coord mx;
        plp_pkg::t_coord mn;
        mx = 32'h7fffffff;
        mn = 32'h80000000;
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_word       = '0;
        idle_pct     = 34;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed words
        send_word('0);
        send_word({9{mx}});
        send_word({9{mn}});
        send_word(make_query(mx, mn, mx, 0, 0, 0, 0, 0, 0));
        send_word(make_query(mx, mx, mx, mn, mn, mn, mn, mn, mn));
        send_word(make_query(mn, mn, mn, mx, mx, mx, mx, mx, mx));
        send_word(make_query(mx, 0, 0, 0, 0, 0, 1, 0, 0));
        send_word(make_query(mn, 0, 0, 0, 0, 0, 1, 0, 0));
        send_word(make_query(0, mx, 0, 0, 0, 0, 0, -1, 0));
        send_word(make_query(mx, mx, mx, mx, mx, mx, mx - 1, mx, mx));
        send_word(make_query(mx, mx, mx, mn, mn, mn, mx, mx, mx));
        send_word(make_query(mn, mx, mn, mx, mn, mx, mn, mx, mn));
        send_word(make_query(5, 5, 5, 5, 5, 5, 9, 1, 3));
        send_word(make_query(9, 1, 3, 5, 5, 5, 9, 1, 3));
        send_word(make_query(1, 0, 0, 0, 0, 0, 2, 0, 0));
        send_word(make_query(1, 0, 0, 0, 0, 0, 3, 0, 0));
        send_word(make_query(-1, 0, 0, 0, 0, 0, 3, 0, 0));
        send_word(make_query(0, 32'h10000, 0, mn, 0, 0, mx, 0, 0));
        send_word(make_query(mx, mx, mx, 0, 0, 0, 0, 0, 1));
        send_word(make_query(mx, 0, mn, mn, 0, mx, mn + 1, 0, mx));

        // drain before the random phases
        @(negedge i_clk);
        while (pending != 0) begin
            @(negedge i_clk);
        end

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 3) begin
                idle_pct = 51;
            end
            if (n == 2 * RANDOM_WORDS / 3) begin
                idle_pct = 0;
            end
            if (n == RANDOM_WORDS / 2) begin
                while (pending != 0) begin
                    @(negedge i_clk);
                end
            end
            send_word(rand_query());
        end

        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (120) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("** point_line_projection_core: PASSED **");
        end else begin
            $display("** point_line_projection_core: FAILED **");
        end
        $finish;
    end
endmodule
